/* rtl/lprl_pkg.sv */
// Shared types and constants for the longest-prefix route lookup block.
// No dependencies; imported by the entry cell and the top level.
`default_nettype none

package lprl_pkg;

  localparam int TABLE_DEPTH = 64;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;
  localparam int SLOT_W  = 6;
  localparam int LIMIT_W = 7;
  // Wide enough for a cell index, a slot and the limit register at any depth up to 255
  localparam int CMP_W   = 8;

  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(ADDR_W);
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  // One token moving down the chain: a table write or a lookup with its best match so far.
  typedef struct packed {
    logic              lookup;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;   // network for a write, destination for a lookup
    logic [LEN_W-1:0]  len;    // prefix length for a write, best length for a lookup
    logic [ADDR_W-1:0] gw;     // next hop for a write, best gateway for a lookup
    logic              hit;
  } token_t;

endpackage

`default_nettype wire

/* rtl/lprl_cell.sv */
// One route table entry and its compare stage in the lookup chain.
// Depends on lprl_pkg for the token type and widths.
`default_nettype none

module lprl_cell
  import lprl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [CMP_W-1:0] cell_idx_i,
  input  wire logic [LIMIT_W-1:0] limit_i,
  input  wire logic             valid_i,
  input  wire token_t           tok_i,
  output logic                  valid_o,
  output token_t                tok_o
);

  logic [ADDR_W-1:0] net_q;
  logic [LEN_W-1:0]  len_q;
  logic [ADDR_W-1:0] gw_q;

  logic              valid_q;
  token_t            tok_q;
  token_t            tok_d;

  logic [LEN_W-1:0]  clen;
  logic [ADDR_W-1:0] mask;
  logic              active;
  logic              match;
  logic              take;
  logic              wr_en;

  always_comb begin
    clen   = (len_q > MAX_LEN) ? MAX_LEN : len_q;
    mask   = ~(ALL_ONES >> clen);
    active = cell_idx_i < {{(CMP_W-LIMIT_W){1'b0}}, limit_i};
    match  = active && (((tok_i.addr ^ net_q) & mask) == '0);
    take   = tok_i.lookup && match && (!tok_i.hit || (clen > tok_i.len));
    wr_en  = en_i && valid_i && !tok_i.lookup &&
             ({{(CMP_W-SLOT_W){1'b0}}, tok_i.slot} == cell_idx_i);
  end

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.hit = 1'b1;
      tok_d.len = clen;
      tok_d.gw  = gw_q;
    end
  end

  // Table entry storage, undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      net_q <= tok_i.addr;
      len_q <= tok_i.len;
      gw_q  <= tok_i.gw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

`default_nettype wire

/* rtl/longest_prefix_route_lookup_top.sv */
// Top level of the longest-prefix route lookup: input token, chain of entry cells, output.
// Depends on lprl_pkg and lprl_cell.
// Each cell of the chain is one register stage, and every lookup passes through the whole chain.
// Throughput: one transaction per cycle, writes and lookups alike, while the output is taken;
// a stalled result holds the whole chain.
// Reset: the limit register clears to zero and the chain empties; table entries are not cleared.
`default_nettype none

module longest_prefix_route_lookup_top
  import lprl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [LIMIT_W-1:0] cfg_data_i,

  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               mode_i,
  input  wire logic [SLOT_W-1:0]  slot_i,
  input  wire logic [ADDR_W-1:0]  network_i,
  input  wire logic [LEN_W-1:0]   prefix_length_i,
  input  wire logic [ADDR_W-1:0]  next_hop_i,
  input  wire logic [ADDR_W-1:0]  destination_i,

  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [ADDR_W-1:0]       gateway_o,
  output logic                    found_o,
  output logic [LEN_W-1:0]        matched_length_o
);

  logic [LIMIT_W-1:0] limit_q;
  logic               advance;

  token_t             chain_tok   [TABLE_DEPTH+1];
  logic               chain_valid [TABLE_DEPTH+1];
  token_t             last_tok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Build the entry token; a lookup starts with no match, length and gateway zero
  always_comb begin
    chain_valid[0]      = in_valid_i;
    chain_tok[0].lookup = mode_i;
    chain_tok[0].slot   = slot_i;
    chain_tok[0].addr   = mode_i ? destination_i : network_i;
    chain_tok[0].len    = mode_i ? '0 : prefix_length_i;
    chain_tok[0].gw     = mode_i ? '0 : next_hop_i;
    chain_tok[0].hit    = 1'b0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lprl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (advance),
      .cell_idx_i (CMP_W'(i)),
      .limit_i    (limit_q),
      .valid_i    (chain_valid[i]),
      .tok_i      (chain_tok[i]),
      .valid_o    (chain_valid[i+1]),
      .tok_o      (chain_tok[i+1])
    );
  end

  assign last_tok = chain_tok[TABLE_DEPTH];

  // Writes drop off the end of the chain; only lookups give a result
  assign out_valid_o      = chain_valid[TABLE_DEPTH] && last_tok.lookup;
  assign advance          = !out_valid_o || out_ready_i;
  assign in_ready_o       = advance;
  assign gateway_o        = last_tok.gw;
  assign found_o          = last_tok.hit;
  assign matched_length_o = last_tok.len;

  a_no_match_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (gateway_o == '0 && matched_length_o == '0))
    else $error("miss result carries nonzero gateway or length");

  a_len_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (matched_length_o <= MAX_LEN))
    else $error("matched length above address width");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input held off without a stalled result");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(gateway_o) &&
      $stable(matched_length_o) && $stable(found_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
